// ===== hdl/segment_sphere_intersect_macros.svh =====
// ----------------------------------------------------------------------------
// Segment/sphere intersect assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SPHERE_INTERSECT_MACROS_SVH
`define SEGMENT_SPHERE_INTERSECT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define SSI_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("segment_sphere_intersect: assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define SSI_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("segment_sphere_intersect: assertion failed");

`else

`define SSI_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define SSI_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere intersect package
// Shared types and arithmetic helpers for the intersect pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

   // Input field types.
   typedef logic signed [15:0] coord_type;
   typedef logic        [15:0] radius_type;

   // Datapath types.
   typedef logic signed [16:0] diff_type;   // difference of two coordinates
   typedef logic        [31:0] sq_type;     // square of a difference, or r^2
   typedef logic signed [32:0] dot_type;    // product of two differences
   typedef logic        [33:0] sum_type;    // sum of three squares
   typedef logic signed [34:0] pdot_type;   // dot product w.d

   // One input beat as seen by the datapath.
   typedef struct packed {
      coord_type  center_x;
      coord_type  center_y;
      coord_type  center_z;
      radius_type radius;
      coord_type  start_x;
      coord_type  start_y;
      coord_type  start_z;
      coord_type  end_x;
      coord_type  end_y;
      coord_type  end_z;
   } ssi_item_type;

   // Reduced quantities handed from the vector half to the compare half.
   typedef struct packed {
      pdot_type p;
      sum_type  dd;
      sum_type  ww;
      sum_type  vv;
      sq_type   r2;
   } ssi_sums_type;

   // Load enables for the three stages of one pipeline half.
   typedef struct packed {
      logic s0;
      logic s1;
      logic s2;
   } ssi_load_type;

   // Sign-extends a coordinate by one bit.
   function automatic diff_type ext17(input coord_type v);
      return {v[15], v};
   endfunction

   // Square of a difference; the magnitude stays below 2^16, so 32 bits hold it.
   function automatic sq_type sq17(input diff_type a);
      logic signed [33:0] t;
      t = a * a;
      return t[31:0];
   endfunction

   // Signed product of two differences.
   function automatic dot_type mul17(input diff_type a, input diff_type b);
      dot_type t;
      t = a * b;
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ssi_req_if.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere request channel
// Valid/ready channel carrying one sphere and one segment per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssi_req_if import ssi_pkg::*;;
   logic       valid;
   logic       ready;
   coord_type  center_x;
   coord_type  center_y;
   coord_type  center_z;
   radius_type radius;
   coord_type  start_x;
   coord_type  start_y;
   coord_type  start_z;
   coord_type  end_x;
   coord_type  end_y;
   coord_type  end_z;

   modport source (
      output valid, center_x, center_y, center_z, radius,
             start_x, start_y, start_z, end_x, end_y, end_z,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, center_z, radius,
             start_x, start_y, start_z, end_x, end_y, end_z,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/ssi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere response channel
// Valid/ready channel carrying one hit flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssi_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (
      output valid, hit,
      input  ready
   );

   modport sink (
      input  valid, hit,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/ssi_vec.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere vector stages
// Stages one to three: differences, products, and the dot and square sums.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_vec import ssi_pkg::*; (
   input  logic         clock,
   input  ssi_load_type load,
   input  ssi_item_type item,
   output ssi_sums_type sums
);

   diff_type d_ff [3];
   diff_type w_ff [3];
   diff_type v_ff [3];
   radius_type r_ff;

   sq_type  sq_d_ff [3];
   sq_type  sq_w_ff [3];
   sq_type  sq_v_ff [3];
   dot_type dot_ff  [3];
   sq_type  r2_ff;

   ssi_sums_type sums_ff;
   ssi_sums_type sums_in;

   coord_type c_pt [3];
   coord_type a_pt [3];
   coord_type b_pt [3];

   always_comb begin
      c_pt[0] = item.center_x;
      c_pt[1] = item.center_y;
      c_pt[2] = item.center_z;
      a_pt[0] = item.start_x;
      a_pt[1] = item.start_y;
      a_pt[2] = item.start_z;
      b_pt[0] = item.end_x;
      b_pt[1] = item.end_y;
      b_pt[2] = item.end_z;
   end

   // Stage one: d = B - A, w = C - A, v = C - B.
   always_ff @(posedge clock) begin
      if (load.s0) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= ext17(b_pt[i]) - ext17(a_pt[i]);
            w_ff[i] <= ext17(c_pt[i]) - ext17(a_pt[i]);
            v_ff[i] <= ext17(c_pt[i]) - ext17(b_pt[i]);
         end
         r_ff <= item.radius;
      end
   end

   // Stage two: one multiplier per product term.
   always_ff @(posedge clock) begin
      if (load.s1) begin
         for (int i = 0; i < 3; i++) begin
            sq_d_ff[i] <= sq17(d_ff[i]);
            sq_w_ff[i] <= sq17(w_ff[i]);
            sq_v_ff[i] <= sq17(v_ff[i]);
            dot_ff[i]  <= mul17(w_ff[i], d_ff[i]);
         end
         r2_ff <= r_ff * r_ff;
      end
   end

   // Stage three: three-term sums, widened so nothing overflows.
   always_comb begin
      sums_in.p  = {{2{dot_ff[0][32]}}, dot_ff[0]}
                 + {{2{dot_ff[1][32]}}, dot_ff[1]}
                 + {{2{dot_ff[2][32]}}, dot_ff[2]};
      sums_in.dd = {2'b00, sq_d_ff[0]} + {2'b00, sq_d_ff[1]} + {2'b00, sq_d_ff[2]};
      sums_in.ww = {2'b00, sq_w_ff[0]} + {2'b00, sq_w_ff[1]} + {2'b00, sq_w_ff[2]};
      sums_in.vv = {2'b00, sq_v_ff[0]} + {2'b00, sq_v_ff[1]} + {2'b00, sq_v_ff[2]};
      sums_in.r2 = r2_ff;
   end

   always_ff @(posedge clock) begin
      if (load.s2) begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

`default_nettype wire

// ===== hdl/ssi_cmp.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere compare stages
// Stages four to six: region select, wide products, and the final compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_cmp import ssi_pkg::*; (
   input  logic         clock,
   input  ssi_load_type load,
   input  ssi_sums_type sums,
   output logic         hit
);

   logic        near_a;
   logic        near_b;
   logic [33:0] p_mag;

   logic        interior_ff;
   logic        simple_hit_ff;
   logic [67:0] lhs_ff;
   logic [65:0] r2dd_ff;
   logic [67:0] pp_ff;

   logic        interior2_ff;
   logic        simple_hit2_ff;
   logic [67:0] lhs2_ff;
   logic [68:0] rhs_ff;

   logic        hit_ff;

   // Region of the nearest point: end A when p <= 0, end B when p >= dd.
   // A positive p stays below 2^34, so its low bits are its magnitude.
   always_comb begin
      p_mag  = sums.p[33:0];
      near_a = sums.p[34] || (sums.p == '0);
      near_b = !near_a && (p_mag >= sums.dd);
   end

   // Stage four: end-point tests and the three wide products.
   always_ff @(posedge clock) begin
      if (load.s0) begin
         interior_ff   <= !near_a && !near_b;
         simple_hit_ff <= near_a ? (sums.ww <= {2'b00, sums.r2})
                                 : (sums.vv <= {2'b00, sums.r2});
         lhs_ff        <= sums.ww * sums.dd;
         r2dd_ff       <= sums.r2 * sums.dd;
         pp_ff         <= p_mag * p_mag;
      end
   end

   // Stage five: right-hand side r^2*dd + p^2.
   always_ff @(posedge clock) begin
      if (load.s1) begin
         interior2_ff   <= interior_ff;
         simple_hit2_ff <= simple_hit_ff;
         lhs2_ff        <= lhs_ff;
         rhs_ff         <= {3'b000, r2dd_ff} + {1'b0, pp_ff};
      end
   end

   // Stage six: interior compare, registered as the output.
   always_ff @(posedge clock) begin
      if (load.s2) begin
         hit_ff <= interior2_ff ? ({1'b0, lhs2_ff} <= rhs_ff) : simple_hit2_ff;
      end
   end

   assign hit = hit_ff;

endmodule

`default_nettype wire

// ===== hdl/segment_sphere_intersect.sv =====
// An accepted request beat passes stages one to six in order before its response beat.
// Throughput: one beat per cycle; a request enters every cycle the pipeline moves.
// The rate is set by the six-stage multiplier pipeline, each stage held by its valid bit.
// A stalled response holds only the stages behind it that are full; bubbles still fill.
// Reset (synchronous, active high) clears every stage valid bit; data is not reset.
// ----------------------------------------------------------------------------
// Segment/sphere intersect top level
// Reports whether the segment point nearest a sphere center lies within its radius.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_sphere_intersect_macros.svh"

module segment_sphere_intersect import ssi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ssi_req_if.sink      req_bus,
   ssi_rsp_if.source    rsp_bus
);

   localparam int Stages = 6;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;
   logic [Stages-1:0] en;

   ssi_item_type item;
   ssi_sums_type sums;
   ssi_load_type load_vec;
   ssi_load_type load_cmp;
   logic         hit;

   // A stage loads when it is empty or when the stage after it moves.
   always_comb begin
      en[Stages-1] = !vld_ff[Stages-1] || rsp_bus.ready;
      for (int i = Stages - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < Stages; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      load_vec.s0 = en[0];
      load_vec.s1 = en[1];
      load_vec.s2 = en[2];
      load_cmp.s0 = en[3];
      load_cmp.s1 = en[4];
      load_cmp.s2 = en[5];
   end

   // Gather the request beat into one item.
   always_comb begin
      item.center_x = req_bus.center_x;
      item.center_y = req_bus.center_y;
      item.center_z = req_bus.center_z;
      item.radius   = req_bus.radius;
      item.start_x  = req_bus.start_x;
      item.start_y  = req_bus.start_y;
      item.start_z  = req_bus.start_z;
      item.end_x    = req_bus.end_x;
      item.end_y    = req_bus.end_y;
      item.end_z    = req_bus.end_z;
   end

   ssi_vec u_vec (
      .clock (clock),
      .load  (load_vec),
      .item  (item),
      .sums  (sums)
   );

   ssi_cmp u_cmp (
      .clock (clock),
      .load  (load_cmp),
      .sums  (sums),
      .hit   (hit)
   );

   assign req_bus.ready = en[0];
   assign rsp_bus.valid = vld_ff[Stages-1];
   assign rsp_bus.hit   = hit;

   // Requests are refused only when every stage holds a beat.
   `SSI_ASSERT_IMPLY(a_full_on_stall, clock, reset, !req_bus.ready, &vld_ff)

   // A degenerate segment (dd of zero) must give a zero dot product.
   `SSI_ASSERT_IMPLY(a_degenerate_dot, clock, reset, vld_ff[2] && (sums.dd == '0), sums.p == '0)

   // The first cycle after reset shows no response beat.
   `SSI_ASSERT_ALWAYS(a_reset_empty, clock, reset, !$past(reset) || !rsp_bus.valid)

endmodule

`default_nettype wire

// ===== tb/tb_segment_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere intersect testbench
// Drives sphere and segment beats into the intersect pipeline and checks every
// hit flag against its table value or an exact integer nearest-distance test.
// A directed table covers touching, zero radius, degenerate segments and the
// coordinate extremes; random beats follow with bursts of idling on both sides.
// ----------------------------------------------------------------------------
module tb_segment_sphere_intersect import ssi_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1300;
   localparam int QUIET_TAIL   = 150;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE       = 20;

   // Which part of the segment lies nearest the center.
   typedef enum int {NEAR_START, NEAR_END, NEAR_INTERIOR} near_type;

   // Where the expected flag of a beat comes from.
   typedef enum logic {BY_PREDICTOR, BY_TABLE} check_src_type;

   typedef struct {
      ssi_item_type  item;
      check_src_type src;
      logic          hit;
   } row_type;

   typedef struct {
      logic hit;
      int   tag;
   } pending_type;

   logic clock = 1'b0;
   logic reset;

   ssi_req_if req_chan ();
   ssi_rsp_if rsp_chan ();

   segment_sphere_intersect u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan.sink),
      .rsp_bus (rsp_chan.source)
   );

   row_type       dir_rows[$];
   pending_type   pending_hits[$];
   int            errors = 0;
   int            accepted = 0;
   int            responses = 0;
   int            hits_seen = 0;
   int            near_count[3] = '{0, 0, 0};
   int            long_holds = 0;
   bit            send_idle = 1'b1;
   bit            recv_idle = 1'b1;
   bit            long_hold_due = 1'b0;
   check_src_type cur_source = BY_PREDICTOR;
   logic          cur_known_hit = 1'b0;
   int            cur_tag = 0;

   always #5 clock = ~clock;

   // Builds one beat from integer coordinates.
   function automatic ssi_item_type mk(input int cx, input int cy, input int cz, input int r,
                                       input int ax, input int ay, input int az,
                                       input int bx, input int by, input int bz);
      ssi_item_type it;
      it.center_x = coord_type'(cx);
      it.center_y = coord_type'(cy);
      it.center_z = coord_type'(cz);
      it.radius   = radius_type'(r);
      it.start_x  = coord_type'(ax);
      it.start_y  = coord_type'(ay);
      it.start_z  = coord_type'(az);
      it.end_x    = coord_type'(bx);
      it.end_y    = coord_type'(by);
      it.end_z    = coord_type'(bz);
      return it;
   endfunction

   // Exact nearest-point test: squared distances only, products kept at 96 bits.
   function automatic logic nearest_hit(input ssi_item_type it, output near_type kind);
      longint cx, cy, cz, ax, ay, az, bx, by, bz;
      longint dx, dy, dz, wx, wy, wz;
      longint dot_wd, len_dd, len_ww, len_vv, rad_sq;
      logic [95:0] lhs, rhs;
      logic result;
      cx = it.center_x; cy = it.center_y; cz = it.center_z;
      ax = it.start_x;  ay = it.start_y;  az = it.start_z;
      bx = it.end_x;    by = it.end_y;    bz = it.end_z;
      rad_sq = longint'(it.radius) * longint'(it.radius);
      dx = bx - ax; dy = by - ay; dz = bz - az;
      wx = cx - ax; wy = cy - ay; wz = cz - az;
      dot_wd = wx * dx + wy * dy + wz * dz;
      len_dd = dx * dx + dy * dy + dz * dz;
      len_ww = wx * wx + wy * wy + wz * wz;
      len_vv = (cx - bx) * (cx - bx) + (cy - by) * (cy - by) + (cz - bz) * (cz - bz);
      if (dot_wd <= 0) begin
         kind = NEAR_START;
         result = (len_ww <= rad_sq);
      end else if (dot_wd >= len_dd) begin
         kind = NEAR_END;
         result = (len_vv <= rad_sq);
      end else begin
         // Interior: |w|^2*dd <= r^2*dd + p^2, all terms non-negative.
         kind = NEAR_INTERIOR;
         lhs = 96'(len_ww) * 96'(len_dd);
         rhs = 96'(rad_sq) * 96'(len_dd) + 96'(dot_wd) * 96'(dot_wd);
         result = (lhs <= rhs);
      end
      return result;
   endfunction

   // A coordinate drawn from the corners of the range, around zero, or anywhere.
   function automatic int corner_coord();
      int pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // One random beat. Most beats are shaped so that all three regions of the
   // segment and the boundary of the sphere are reached often.
   function automatic ssi_item_type random_item();
      int roll, k, span, reach, mode, tmp, r;
      int base[3], a[3], b[3], c[3];
      roll = $urandom_range(0, 99);
      k = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
         base[j] = int'($urandom_range(0, 60000)) - 30000;
         a[j] = base[j] + int'($urandom_range(0, 80)) - 40;
         b[j] = base[j] + int'($urandom_range(0, 80)) - 40;
         c[j] = base[j] + int'($urandom_range(0, 80)) - 40;
      end
      r = $urandom_range(0, 60);
      if (roll < 30) begin
         // Anywhere in the coordinate space, any radius.
         for (int j = 0; j < 3; j++) begin
            a[j] = int'($urandom_range(0, 65535)) - 32768;
            b[j] = int'($urandom_range(0, 65535)) - 32768;
            c[j] = int'($urandom_range(0, 65535)) - 32768;
         end
         r = $urandom_range(0, 65535);
      end else if (roll < 65) begin
         // Small cluster: keeps the three regions and near misses frequent.
      end else if (roll < 75) begin
         // Degenerate segment.
         for (int j = 0; j < 3; j++) b[j] = a[j];
      end else if (roll < 85) begin
         // Sphere surface close to the segment: radius is the exact distance,
         // or one off on either side.
         span = $urandom_range(1, 60);
         reach = $urandom_range(0, 40);
         mode = $urandom_range(0, 2);
         for (int j = 0; j < 3; j++) begin
            a[j] = base[j];
            b[j] = base[j];
            c[j] = base[j];
         end
         b[0] = base[0] + span;
         case (mode)
            0: begin
               c[0] = base[0] + int'($urandom_range(0, span));
               c[1] = ($urandom_range(0, 1) == 0) ? base[1] + reach : base[1] - reach;
            end
            1: c[0] = base[0] - reach;
            default: c[0] = base[0] + span + reach;
         endcase
         r = reach + int'($urandom_range(0, 2)) - 1;
         if (r < 0) r = 0;
         if ($urandom_range(0, 1) == 1) begin
            for (int j = 0; j < 3; j++) begin
               tmp = a[j]; a[j] = b[j]; b[j] = tmp;
            end
         end
      end else if (roll < 90) begin
         // Zero radius with the center on the segment: midpoint or an end.
         mode = $urandom_range(0, 2);
         for (int j = 0; j < 3; j++) begin
            tmp = int'($urandom_range(0, 40)) - 20;
            b[j] = a[j] + 2 * tmp;
            c[j] = (mode == 0) ? a[j] + tmp : (mode == 1) ? a[j] : b[j];
         end
         r = 0;
      end else begin
         // Extreme coordinates and radii.
         for (int j = 0; j < 3; j++) begin
            a[j] = corner_coord();
            b[j] = corner_coord();
            c[j] = corner_coord();
         end
         mode = $urandom_range(0, 3);
         r = (mode == 0) ? 0 : (mode == 1) ? 65535 : (mode == 2) ? 1
                                                                : $urandom_range(0, 65535);
      end
      return mk(c[k], c[(k + 1) % 3], c[(k + 2) % 3], r,
                a[k], a[(k + 1) % 3], a[(k + 2) % 3],
                b[k], b[(k + 1) % 3], b[(k + 2) % 3]);
   endfunction

   // Offers one request beat, after an optional idle burst, and waits until it
   // is taken.
   task automatic send_item(input ssi_item_type item, input check_src_type src,
                            input logic known, input int tag);
      int gap;
      if (send_idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.center_x <= item.center_x;
      req_chan.center_y <= item.center_y;
      req_chan.center_z <= item.center_z;
      req_chan.radius   <= item.radius;
      req_chan.start_x  <= item.start_x;
      req_chan.start_y  <= item.start_y;
      req_chan.start_z  <= item.start_z;
      req_chan.end_x    <= item.end_x;
      req_chan.end_y    <= item.end_y;
      req_chan.end_z    <= item.end_z;
      cur_source    = src;
      cur_known_hit = known;
      cur_tag       = tag;
      do @(posedge clock);
      while (!(req_chan.valid === 1'b1 && req_chan.ready === 1'b1));
   endtask

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_due) begin
            long_hold_due = 1'b0;
            long_holds++;
            hold_left = LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 17) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Records the expected flag of every accepted request beat and compares
   // every accepted response beat with the oldest one.
   always @(posedge clock) begin : monitor
      ssi_item_type beat;
      near_type     kind;
      logic         predicted;
      pending_type  entry;
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            beat.center_x = req_chan.center_x;
            beat.center_y = req_chan.center_y;
            beat.center_z = req_chan.center_z;
            beat.radius   = req_chan.radius;
            beat.start_x  = req_chan.start_x;
            beat.start_y  = req_chan.start_y;
            beat.start_z  = req_chan.start_z;
            beat.end_x    = req_chan.end_x;
            beat.end_y    = req_chan.end_y;
            beat.end_z    = req_chan.end_z;
            predicted = nearest_hit(beat, kind);
            near_count[kind]++;
            entry.hit = (cur_source == BY_TABLE) ? cur_known_hit : predicted;
            entry.tag = cur_tag;
            pending_hits.push_back(entry);
            accepted++;
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            responses++;
            if (rsp_chan.hit === 1'b1) hits_seen++;
            if (pending_hits.size() == 0) begin
               errors++;
               $display("%0t: response beat hit=%b with nothing expected", $time, rsp_chan.hit);
            end else begin
               entry = pending_hits.pop_front();
               if (rsp_chan.hit !== entry.hit) begin
                  errors++;
                  $display("%0t: beat %0d hit expected %b, actual %b",
                           $time, entry.tag, entry.hit, rsp_chan.hit);
               end
            end
         end
      end
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #5000000;
      $display("FAIL segment_sphere_intersect");
      $finish;
   end

   initial begin : stimulus
      int tag;
      int drain_wait;
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.center_x = '0;
      req_chan.center_y = '0;
      req_chan.center_z = '0;
      req_chan.radius   = '0;
      req_chan.start_x  = '0;
      req_chan.start_y  = '0;
      req_chan.start_z  = '0;
      req_chan.end_x    = '0;
      req_chan.end_y    = '0;
      req_chan.end_z    = '0;

      // Directed table: center, radius, start point, end point.
      // Degenerate segments, zero radius and touching.
      dir_rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0), BY_TABLE, 1'b0});
      dir_rows.push_back('{mk(8, 9, 5, 5, 5, 5, 5, 5, 5, 5), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(8, 9, 5, 4, 5, 5, 5, 5, 5, 5), BY_TABLE, 1'b0});
      dir_rows.push_back('{mk(12, -5, 0, 13, 0, 0, 0, 0, 0, 0), BY_TABLE, 1'b1});
      // Extreme coordinates with the largest radius.
      dir_rows.push_back('{mk(32767, 32767, 32767, 65535, -32768, -32768, -32768,
                              -32768, -32768, -32768), BY_TABLE, 1'b0});
      dir_rows.push_back('{mk(32767, 0, 0, 65535, -32768, 0, 0, -32768, 0, 0),
                           BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(-32768, 32767, -32768, 65535, 32767, -32768, 32767,
                              32767, -32768, 32767), BY_TABLE, 1'b0});
      dir_rows.push_back('{mk(-32768, -32768, -32768, 65535, 32767, 32767, 32767,
                              -32768, -32768, -32768), BY_TABLE, 1'b1});
      // Nearest point inside the segment, touching and just outside.
      dir_rows.push_back('{mk(0, 3, 0, 3, -10, 0, 0, 10, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(0, 3, 0, 2, -10, 0, 0, 10, 0, 0), BY_TABLE, 1'b0});
      // Nearest point is the start point.
      dir_rows.push_back('{mk(-3, 4, 0, 5, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(-3, 4, 0, 4, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b0});
      // Nearest point is the end point.
      dir_rows.push_back('{mk(13, 4, 0, 5, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(13, 4, 0, 4, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b0});
      // Projection exactly on either end.
      dir_rows.push_back('{mk(10, 7, 0, 7, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(0, 7, 0, 6, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b0});
      // Zero radius, center on the segment and just beside it.
      dir_rows.push_back('{mk(5, 0, 0, 0, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b1});
      dir_rows.push_back('{mk(5, 1, 0, 0, 0, 0, 0, 10, 0, 0), BY_TABLE, 1'b0});
      // Long diagonals and mixed cases.
      dir_rows.push_back('{mk(0, 0, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767),
                           BY_PREDICTOR, 1'b0});
      dir_rows.push_back('{mk(32767, -32768, 0, 65535, -32768, -32768, -32768,
                              32767, 32767, 32767), BY_PREDICTOR, 1'b0});
      dir_rows.push_back('{mk(-1, -1, -1, 65535, 32767, -32768, 32767,
                              -32768, 32767, -32768), BY_PREDICTOR, 1'b0});
      dir_rows.push_back('{mk(1, 5, 3, 2, 0, 0, 0, 6, 6, 6), BY_PREDICTOR, 1'b0});
      dir_rows.push_back('{mk(-7, 2, 9, 1, 4, -4, 4, -4, 4, -4), BY_PREDICTOR, 1'b0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tag = 0;
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].item, dir_rows[i].src, dir_rows[i].hit, tag);
         tag++;
      end

      // Random part: idling changes every hundred beats and stops near the end.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i >= RANDOM_BEATS - QUIET_TAIL) begin
            send_idle = 1'b0;
            recv_idle = 1'b0;
         end else begin
            send_idle = ((i / 100) % 3 != 1);
            recv_idle = ((i / 100) % 3 != 2);
         end
         // Long response stall while requests keep coming back to back.
         if (i == 120) long_hold_due = 1'b1;
         send_item(random_item(), BY_PREDICTOR, 1'b0, tag);
         tag++;
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      drain_wait = 0;
      while (pending_hits.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE) @(posedge clock);
      if (pending_hits.size() != 0) begin
         errors++;
         $display("%0t: %0d expected response beats never arrived, oldest is beat %0d",
                  $time, pending_hits.size(), pending_hits[0].tag);
      end

      $display("Checked %0d response beats from %0d request beats: %0d hits, %0d misses.",
               responses, accepted, hits_seen, responses - hits_seen);
      $display("Nearest point at start %0d, at end %0d, inside %0d; long stalls %0d.",
               near_count[NEAR_START], near_count[NEAR_END], near_count[NEAR_INTERIOR],
               long_holds);
      if (errors == 0) begin
         $display("PASS segment_sphere_intersect");
      end else begin
         $display("FAIL segment_sphere_intersect");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ssi_pkg.sv
hdl/ssi_req_if.sv
hdl/ssi_rsp_if.sv
hdl/ssi_vec.sv
hdl/ssi_cmp.sv
hdl/segment_sphere_intersect.sv
tb/tb_segment_sphere_intersect.sv
